// ===== rtl/bdec_pkg.sv =====
`timescale 1ns / 1ps
// bdec_pkg: shared types, constants and the character map of the base64 decoder
// no dependencies; used by the front, queue, back and top rtl files and the testbench
package bdec_pkg;

    // base64 pad character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // group slot that completes a group of four
    localparam logic [1:0] SLOT_LAST = 2'd3;

    // one decoded group or an end-of-string marker, as queued for output
    typedef struct packed {
        logic [2:0][7:0] bytes;     // bytes in emission order, index 0 first
        logic [1:0]      last_idx;  // index of the final beat of this entry
        logic            has;       // entry carries bytes
        logic            str_end;   // final beat closes the string
        logic            bad;       // error flag for the final beat
    } bdec_cmd_t;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } bdec_q_stat_t;

    // map a character to {invalid, sextet}; invalid set outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        case (c) inside
            [8'h41:8'h5A]: r = {1'b0, 6'(c - 8'h41)};
            [8'h61:8'h7A]: r = {1'b0, 6'(c - 8'h61 + 8'd26)};
            [8'h30:8'h39]: r = {1'b0, 6'(c - 8'h30 + 8'd52)};
            8'h2B:         r = {1'b0, 6'd62};
            8'h2F:         r = {1'b0, 6'd63};
            default:       r = 7'h40;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bdec_ifs.sv =====
`timescale 1ns / 1ps
// bdec_in_if, bdec_out_if: valid/ready channels for characters and decoded beats
// no dependencies
interface bdec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       is_last;

    modport source (output valid, output in_char, output is_last, input ready);
    modport sink (input valid, input in_char, input is_last, output ready);
endinterface

interface bdec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_run;
    logic       end_of_string;
    logic       bad_input;

    modport source (output valid, output out_byte, output has_byte, output end_of_run,
                    output end_of_string, output bad_input, input ready);
    modport sink (input valid, input out_byte, input has_byte, input end_of_run,
                  input end_of_string, input bad_input, output ready);
endinterface

// ===== rtl/bdec_front.sv =====
`timescale 1ns / 1ps
// bdec_front: accepts characters, gathers groups of four and builds queue entries
// depends on bdec_pkg and bdec_in_if
module bdec_front
    import bdec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bdec_in_if.sink      in_ch,
    input  bdec_q_stat_t q_stat,
    output logic         push,
    output bdec_cmd_t    cmd
);

    logic [1:0]  slot_reg, slot_next;
    logic [17:0] store_reg, store_next;
    logic        tp_reg, tp_next;
    logic        err_reg, err_next;

    logic        accept;
    logic        is_pad;
    logic [6:0]  map;
    logic [5:0]  v;
    logic        err_now;
    logic [5:0]  s0, s1, s2;
    logic [7:0]  b0, b1, b2;

    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;

    // classify the character
    assign is_pad  = (in_ch.in_char == PAD_CHAR);
    assign map     = sextet_of(in_ch.in_char);
    assign v       = (is_pad || map[6]) ? 6'd0 : map[5:0];
    assign err_now = err_reg || (!is_pad && map[6]);

    // bytes of a completed group
    assign s0 = store_reg[17:12];
    assign s1 = store_reg[11:6];
    assign s2 = store_reg[5:0];
    assign b0 = {s0, s1[5:4]};
    assign b1 = {s1[3:0], s2[5:2]};
    assign b2 = {s2[1:0], v};

    // queue entry
    always_comb
    begin
        cmd  = '0;
        push = 1'b0;
        if (slot_reg == SLOT_LAST)
        begin
            push          = accept;
            cmd.has       = 1'b1;
            cmd.bytes[0]  = b0;
            cmd.bytes[1]  = tp_reg ? b2 : b1;
            cmd.bytes[2]  = b2;
            cmd.last_idx  = 2'(2'(!tp_reg) + 2'(!is_pad));
            cmd.str_end   = in_ch.is_last;
            cmd.bad       = in_ch.is_last && err_now;
        end
        else
        begin
            // string ends inside a group
            push         = accept && in_ch.is_last;
            cmd.has      = 1'b0;
            cmd.last_idx = 2'd0;
            cmd.str_end  = 1'b1;
            cmd.bad      = 1'b1;
        end
    end

    // group state update
    always_comb
    begin
        slot_next  = slot_reg;
        store_next = store_reg;
        tp_next    = tp_reg;
        err_next   = err_reg;
        if (accept)
        begin
            err_next = err_now;
            if (slot_reg == SLOT_LAST)
            begin
                slot_next  = 2'd0;
                store_next = '0;
                tp_next    = 1'b0;
            end
            else
            begin
                slot_next  = 2'(slot_reg + 2'd1);
                store_next = {store_reg[11:0], v};
                if (slot_reg == 2'd2)
                begin
                    tp_next = is_pad;
                end
            end
            if (in_ch.is_last)
            begin
                slot_next  = 2'd0;
                store_next = '0;
                tp_next    = 1'b0;
                err_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            store_reg <= '0;
            tp_reg    <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            store_reg <= store_next;
            tp_reg    <= tp_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== rtl/bdec_queue.sv =====
`timescale 1ns / 1ps
// bdec_queue: small fifo of decoded groups between the front and back parts
// depends on bdec_pkg
module bdec_queue
    import bdec_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  bdec_cmd_t    wr_cmd,
    input  logic         pop,
    output bdec_cmd_t    rd_cmd,
    output bdec_q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bdec_cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_cmd     = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/bdec_back.sv =====
`timescale 1ns / 1ps
// bdec_back: takes queued groups and sends their bytes one beat per cycle while not stalled
// depends on bdec_pkg and bdec_out_if
module bdec_back
    import bdec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bdec_q_stat_t q_stat,
    input  bdec_cmd_t    head,
    output logic         pop,
    bdec_out_if.source   out_ch
);

    bdec_cmd_t  cur_reg, cur_next;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       fire;
    logic       last_beat;
    logic       load;

    assign fire      = out_ch.valid && out_ch.ready;
    assign last_beat = (idx_reg == cur_reg.last_idx);
    assign load      = !valid_reg || (fire && last_beat);
    assign pop       = load && !q_stat.empty;

    // beat fields from the held entry
    assign out_ch.valid         = valid_reg;
    assign out_ch.out_byte      = cur_reg.has ? cur_reg.bytes[idx_reg] : 8'd0;
    assign out_ch.has_byte      = cur_reg.has;
    assign out_ch.end_of_run    = last_beat;
    assign out_ch.end_of_string = last_beat && cur_reg.str_end;
    assign out_ch.bad_input     = last_beat && cur_reg.str_end && cur_reg.bad;

    // advance within an entry or load the next one
    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = !q_stat.empty;
            cur_next   = head;
            idx_next   = 2'd0;
        end
        else if (fire)
        begin
            idx_next = 2'(idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

// ===== rtl/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// base64 stream decoder: one character accepted per cycle while the queue has room
// a group's first beat shows after it passes the queue and the back's held entry
// output: one beat per cycle unless stalled; up to three beats per four characters
// throughput is set by the front accepting a character and the back sending a beat
// every cycle while not stalled; asynchronous active-low reset empties the queue
module base64_stream_decoder
    import bdec_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    bdec_in_if.sink    in_ch,
    bdec_out_if.source out_ch
);

    bdec_cmd_t    push_cmd;
    bdec_cmd_t    head_cmd;
    bdec_q_stat_t q_stat;
    logic         push;
    logic         pop;

    // character intake and grouping
    bdec_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_stat (q_stat),
        .push   (push),
        .cmd    (push_cmd)
    );

    // group queue
    bdec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (push_cmd),
        .pop    (pop),
        .rd_cmd (head_cmd),
        .stat   (q_stat)
    );

    // beat output
    bdec_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head_cmd),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// ===== rtl/bdec_checker.sv =====
`timescale 1ns / 1ps
// bdec_checker: port-level checks on the decoder output channel
// bound to base64_stream_decoder; no package dependency
module bdec_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       has_byte,
    input logic       end_of_run,
    input logic       end_of_string,
    input logic       bad_input
);

    // a stalled beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // error flag only on the closing beat of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_input |-> end_of_string)
        else $error("bad_input outside end of string");

    // string end always closes a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> end_of_run)
        else $error("end_of_string without end_of_run");

    // a beat without a byte is the short-string error marker
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> out_byte == 8'd0 && bad_input && end_of_string)
        else $error("empty beat is not an error marker");

endmodule

bind base64_stream_decoder bdec_checker u_bdec_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .has_byte      (out_ch.has_byte),
    .end_of_run    (out_ch.end_of_run),
    .end_of_string (out_ch.end_of_string),
    .bad_input     (out_ch.bad_input)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench for base64_stream_decoder: base64 text in, decoded beats checked against a local decoder
// depends on bdec_pkg and the bdec_in_if / bdec_out_if channel interfaces
module testbench;
    import bdec_pkg::*;

    // one decoded beat as seen on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_run;
        logic       end_of_string;
        logic       bad_input;
    } beat_t;

    localparam logic [1:0] SLOT_THIRD    = 2'd2;
    localparam int         MAX_GAP       = 8;
    localparam int         REPORT_LIMIT  = 10;
    localparam int         TARGET_CHARS  = 220;
    localparam int         STALL_CYCLES  = 150;
    localparam int         SETTLE_CYCLES = 20;

    logic clk;
    logic rst_n;

    bdec_in_if  in_ch();
    bdec_out_if out_ch();

    base64_stream_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // local decoder state
    logic [1:0]  slot_pos;
    logic [17:0] held_sextets;
    logic        pad_in_third;
    logic        bad_seen;

    beat_t       beats_due[$];
    logic [7:0]  text_q[$];
    int          failures;
    int          chars_sent;
    bit          src_idle_on;
    bit          sink_idle_on;
    int          sink_hold;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2ms;
        $display("testbench failed");
        $finish;
    end

    // character to {invalid, sextet}
    function automatic logic [6:0] decode_char(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return {1'b0, 6'(c - "A")};
        if (c >= "a" && c <= "z")
            return {1'b0, 6'(c - "a" + 8'd26)};
        if (c >= "0" && c <= "9")
            return {1'b0, 6'(c - "0" + 8'd52)};
        if (c == "+")
            return 7'd62;
        if (c == "/")
            return 7'd63;
        return 7'h40;
    endfunction

    // sextet to its character in the alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        if (s < 6'd26)
            return 8'(8'h41 + s);
        if (s < 6'd52)
            return 8'(8'h61 + s - 8'd26);
        if (s < 6'd62)
            return 8'(8'h30 + s - 8'd52);
        if (s == 6'd62)
            return 8'h2B;
        return 8'h2F;
    endfunction

    function automatic beat_t make_beat(input logic [7:0] b, input logic has, input logic run_end,
                                        input logic str_end, input logic bad);
        beat_t r;
        r.out_byte      = b;
        r.has_byte      = has;
        r.end_of_run    = run_end;
        r.end_of_string = str_end;
        r.bad_input     = bad;
        return r;
    endfunction

    // append a beat to the list of beats due
    function automatic void add_beat(input beat_t b);
        beats_due.insert(beats_due.size(), b);
    endfunction

    // append a character to the text to send
    function automatic void add_char(input logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic void clear_decoder();
        slot_pos     = '0;
        held_sextets = '0;
        pad_in_third = 1'b0;
        bad_seen     = 1'b0;
    endfunction

    // work out the beats that one accepted character causes
    function automatic void decode_step(input logic [7:0] c, input logic last);
        logic [6:0] m;
        logic       pad;
        logic [5:0] v;
        logic [5:0] s0;
        logic [5:0] s1;
        logic [5:0] s2;
        logic [7:0] grp[3];
        int         n;
        logic       fin;

        pad = (c == PAD_CHAR);
        v   = '0;
        if (!pad)
        begin
            m = decode_char(c);
            if (m[6])
                bad_seen = 1'b1;
            else
                v = m[5:0];
        end

        if (slot_pos != SLOT_LAST)
        begin
            if (slot_pos == SLOT_THIRD)
                pad_in_third = pad;
            held_sextets = {held_sextets[11:0], v};
            slot_pos     = slot_pos + 2'd1;
            // string ends inside a group
            if (last)
                add_beat(make_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        end
        else
        begin
            {s0, s1, s2} = held_sextets;
            grp[0] = {s0, s1[5:4]};
            n = 1;
            if (!pad_in_third)
            begin
                grp[n] = {s1[3:0], s2[5:2]};
                n++;
            end
            if (!pad)
            begin
                grp[n] = {s2[1:0], v};
                n++;
            end
            for (int i = 0; i < n; i++)
            begin
                fin = (i == n - 1);
                add_beat(make_beat(grp[i], 1'b1, fin, fin && last, fin && last && bad_seen));
            end
            slot_pos     = '0;
            held_sextets = '0;
            pad_in_third = 1'b0;
        end

        if (last)
            clear_decoder();
    endfunction

    task automatic note_failure(input string msg);
        if (failures < REPORT_LIMIT)
            $display("%s", msg);
        failures++;
    endtask

    // receiving side: random gaps per beat, plus a long hold when asked
    initial
    begin
        int gap;
        gap = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                gap = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (sink_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                sink_hold--;
            end
            else if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                gap--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // beat checker: every accepted beat against the oldest one due
    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = make_beat(out_ch.out_byte, out_ch.has_byte, out_ch.end_of_run,
                            out_ch.end_of_string, out_ch.bad_input);
            if (beats_due.size() == 0)
                note_failure($sformatf("unexpected beat: byte %02h has %0d run %0d str %0d bad %0d",
                             got.out_byte, got.has_byte, got.end_of_run, got.end_of_string,
                             got.bad_input));
            else
            begin
                want = beats_due.pop_front();
                if (got.out_byte != want.out_byte || got.has_byte != want.has_byte
                    || got.end_of_run != want.end_of_run
                    || got.end_of_string != want.end_of_string
                    || got.bad_input != want.bad_input)
                    note_failure($sformatf({"beat mismatch: expected byte %02h has %0d run %0d",
                                 " str %0d bad %0d, got byte %02h has %0d run %0d str %0d bad %0d"},
                                 want.out_byte, want.has_byte, want.end_of_run,
                                 want.end_of_string, want.bad_input, got.out_byte,
                                 got.has_byte, got.end_of_run, got.end_of_string,
                                 got.bad_input));
            end
        end
    end

    // offer one character and wait until it is accepted
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_char <= c;
        in_ch.is_last <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        decode_step(c, last);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic add_string(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    // sender stops until every beat due has arrived
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_due.size() != 0);
    endtask

    // well-formed text from random bytes, pads mostly on the final group
    task automatic make_encoded_text(input int groups);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        int         pads;
        text_q.delete();
        for (int g = 0; g < groups; g++)
        begin
            b0   = 8'($urandom_range(0, 255));
            b1   = 8'($urandom_range(0, 255));
            b2   = 8'($urandom_range(0, 255));
            pads = 0;
            if (g == groups - 1 || $urandom_range(0, 9) == 0)
                pads = $urandom_range(0, 2);
            add_char(sextet_char(b0[7:2]));
            add_char(sextet_char({b0[1:0], b1[7:4]}));
            add_char(pads == 2 ? PAD_CHAR : sextet_char({b1[3:0], b2[7:6]}));
            add_char(pads >= 1 ? PAD_CHAR : sextet_char(b2[5:0]));
        end
    endtask

    // damage some strings: stray byte, wrong length or pure noise
    task automatic corrupt_text();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        else if (pick == 1)
        begin
            repeat ($urandom_range(1, 3))
            begin
                if (text_q.size() > 1)
                    void'(text_q.pop_back());
            end
        end
        else if (pick == 2)
            add_char(sextet_char(6'($urandom_range(0, 63))));
        else if (pick == 3)
        begin
            text_q.delete();
            repeat ($urandom_range(1, 6))
                add_char(8'($urandom_range(0, 255)));
        end
    endtask

    // range edges, pads in first, third and fourth place, invalid bytes, short strings
    task automatic test_directed();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        text_q.delete();
        add_string("AZaz09+/");
        send_text();
        text_q.delete();
        add_string("QQ==");
        send_text();
        text_q.delete();
        add_string("QUI=");
        send_text();
        text_q.delete();
        add_string("=A=A");
        send_text();
        text_q.delete();
        add_char(8'h00);
        add_string("AA");
        add_char(8'hFF);
        send_text();
        text_q.delete();
        add_string("Q");
        send_text();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_stall();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        make_encoded_text(8);
        sink_hold = STALL_CYCLES;
        send_text();
        wait_drained();
    endtask

    // random strings with random idling on both sides
    task automatic test_random_strings();
        int strings;
        strings = 0;
        while (chars_sent < TARGET_CHARS)
        begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            make_encoded_text($urandom_range(1, 4));
            if ($urandom_range(0, 3) == 0)
                corrupt_text();
            send_text();
            strings++;
            if (strings % 8 == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        failures      = 0;
        chars_sent    = 0;
        src_idle_on   = 1'b0;
        sink_idle_on  = 1'b0;
        sink_hold     = 0;
        clear_decoder();
        in_ch.valid   <= 1'b0;
        in_ch.in_char <= 8'h00;
        in_ch.is_last <= 1'b0;
        rst_n         <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_stall();
        test_random_strings();

        // let the last beats out, then watch for strays
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bdec_pkg.sv
rtl/bdec_ifs.sv
rtl/bdec_front.sv
rtl/bdec_queue.sv
rtl/bdec_back.sv
rtl/base64_stream_decoder.sv
rtl/bdec_checker.sv
bench/testbench.sv
